@@ rtl/core/dsm_pkg.sv @@
package dsm_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int PIDX_W     = IDX_W + 1;
    localparam int PROD_DEPTH = 2 * MAX_DIGITS;
    localparam int TOT_W      = PIDX_W + 1;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [6:0] RADIX     = 7'd10;

    typedef struct packed {
        logic       mode;
        logic [3:0] digit;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [3:0] product_digit;
        logic       last_res;
        logic       overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MRD,
        S_MAC,
        S_CARRY,
        S_ORD,
        S_OSHOW
    } dsm_state_t;

    // Split a value 0..99 into {tens, units}.
    function automatic logic [7:0] dec_split(input logic [6:0] s);
        logic [3:0] hi;
        logic [6:0] lo;
        hi = 4'd0;
        for (int t = 1; t <= 9; t++) begin
            if (s >= 7'(10 * t)) begin
                hi = 4'(t);
            end
        end
        lo = s - ({3'b000, hi} * RADIX);
        return {hi, lo[3:0]};
    endfunction

endpackage

@@ rtl/core/decimal_schoolbook_multiplier.sv @@
// Channel | Direction | Handshake         | Word
// s_      | in        | s_valid / s_ready | in_word_t  {mode, digit, last}
// m_      | out       | m_valid / m_ready | out_word_t {product_digit, last_res, overflow}
//
// A load word is taken in S_IDLE; s_ready is high only while no product is in work.
// A start word leads to a setup state, then NB rows of S_MRD, S_MAC, S_CARRY (a read, one digit pair
// a cycle, a carry write; NA, NB = counts); an empty operand skips the rows.
// Each product digit is then read from the product RAM (S_ORD) and shown on m_ (S_OSHOW).
// aresetn is synchronous, active low; it clears counts, drop flag and state.
// A stalled m_ready holds the word on m_ and the block waits with it.
module decimal_schoolbook_multiplier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dsm_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output dsm_pkg::out_word_t m_word
);
    import dsm_pkg::*;

    dsm_state_t state_reg, state_next;

    // operand and product stores
    logic [3:0] a_mem [MAX_DIGITS];
    logic [3:0] b_mem [MAX_DIGITS];
    logic [3:0] p_mem [PROD_DEPTH];
    logic [PROD_DEPTH-1:0] pv_reg;  // product entry written since start

    logic [CNT_W-1:0]  na_reg, nb_reg;
    logic              drop_reg;
    logic [IDX_W-1:0]  i_reg, j_reg;
    logic [3:0]        carry_reg;
    logic [TOT_W-1:0]  k_reg, total_reg;

    logic [3:0] a_rd_reg, b_rd_reg, p_rd_reg;
    logic       pv_rd_reg;

    logic              s_fire, m_fire;
    logic [3:0]        din_sat;
    logic              last_i, last_j, last_out, empty_op;
    logic [IDX_W-1:0]  i_raddr;
    logic [PIDX_W-1:0] p_raddr, p_waddr;
    logic [3:0]        p_wdata;
    logic              p_we, p_re;
    logic [3:0]        p_dig;
    logic [6:0]        mac_sum;
    logic [7:0]        mac_split;
    logic [TOT_W-1:0]  total_raw;

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign din_sat  = (s_word.digit > DIGIT_MAX) ? DIGIT_MAX : s_word.digit;
    assign last_i   = (CNT_W'(i_reg) + CNT_W'(1)) == na_reg;
    assign last_j   = (CNT_W'(j_reg) + CNT_W'(1)) == nb_reg;
    assign last_out = (k_reg + TOT_W'(1)) == total_reg;
    assign empty_op = (na_reg == '0) || (nb_reg == '0);
    assign total_raw = TOT_W'(na_reg) + TOT_W'(nb_reg);

    // MAC: digit pair product plus partial product digit plus running carry
    assign p_dig     = pv_rd_reg ? p_rd_reg : 4'd0;
    assign mac_sum   = ({3'b000, a_rd_reg} * {3'b000, b_rd_reg}) + {3'b000, p_dig}
                     + {3'b000, carry_reg};
    assign mac_split = dec_split(mac_sum);

    // next read is issued while the current pair is accumulated
    assign i_raddr = (state_reg == S_MAC) ? (i_reg + IDX_W'(1)) : i_reg;

    always_comb begin
        p_raddr = PIDX_W'(i_raddr) + PIDX_W'(j_reg);
        if (state_reg == S_ORD) begin
            p_raddr = k_reg[PIDX_W-1:0];
        end
    end

    always_comb begin
        p_waddr = PIDX_W'(i_reg) + PIDX_W'(j_reg);
        p_wdata = mac_split[3:0];
        if (state_reg == S_CARRY) begin
            p_waddr = PIDX_W'(na_reg) + PIDX_W'(j_reg);
            p_wdata = carry_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && s_word.mode && s_word.last) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = empty_op ? S_ORD : S_MRD;
            end
            S_MRD: begin
                state_next = S_MAC;
            end
            S_MAC: begin
                if (last_i) begin
                    state_next = S_CARRY;
                end
            end
            S_CARRY: begin
                state_next = last_j ? S_ORD : S_MRD;
            end
            S_ORD: begin
                state_next = S_OSHOW;
            end
            S_OSHOW: begin
                if (m_ready) begin
                    state_next = last_out ? S_IDLE : S_ORD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and strobes
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        p_we    = 1'b0;
        p_re    = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            S_START: ;
            S_MRD:   p_re = 1'b1;
            S_MAC: begin
                p_we = 1'b1;
                p_re = 1'b1;
            end
            S_CARRY: p_we = 1'b1;
            S_ORD:   p_re = 1'b1;
            S_OSHOW: m_valid = 1'b1;
            default: ;
        endcase
    end

    assign m_word.product_digit = p_dig;
    assign m_word.last_res      = last_out;
    assign m_word.overflow      = drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            na_reg    <= '0;
            nb_reg    <= '0;
            drop_reg  <= 1'b0;
            pv_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            carry_reg <= '0;
            k_reg     <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                // count the digit, or drop it once the operand is full
                if (!s_word.mode) begin
                    if (na_reg < CNT_W'(MAX_DIGITS)) begin
                        na_reg <= na_reg + CNT_W'(1);
                    end else begin
                        drop_reg <= 1'b1;
                    end
                end else begin
                    if (nb_reg < CNT_W'(MAX_DIGITS)) begin
                        nb_reg <= nb_reg + CNT_W'(1);
                    end else begin
                        drop_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == S_START) begin
                pv_reg    <= '0;
                i_reg     <= '0;
                j_reg     <= '0;
                carry_reg <= '0;
                k_reg     <= '0;
                total_reg <= (total_raw == '0) ? TOT_W'(1) : total_raw;
            end else if (p_we) begin
                pv_reg[p_waddr] <= 1'b1;
            end
            if (state_reg == S_MAC) begin
                carry_reg <= mac_split[7:4];
                if (!last_i) begin
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
            if (state_reg == S_CARRY) begin
                i_reg     <= '0;
                carry_reg <= '0;
                if (!last_j) begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            if (m_fire) begin
                k_reg <= k_reg + TOT_W'(1);
                // drop the finished problem
                if (last_out) begin
                    na_reg   <= '0;
                    nb_reg   <= '0;
                    drop_reg <= 1'b0;
                end
            end
        end
    end

    // operand stores
    always_ff @(posedge aclk) begin
        if (s_fire && !s_word.mode && (na_reg < CNT_W'(MAX_DIGITS))) begin
            a_mem[na_reg[IDX_W-1:0]] <= din_sat;
        end
        if (s_fire && s_word.mode && (nb_reg < CNT_W'(MAX_DIGITS))) begin
            b_mem[nb_reg[IDX_W-1:0]] <= din_sat;
        end
        a_rd_reg <= a_mem[i_raddr];
        b_rd_reg <= b_mem[j_reg];
    end

    // product store
    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        if (p_re) begin
            p_rd_reg  <= p_mem[p_raddr];
            pv_rd_reg <= pv_reg[p_raddr];
        end
    end

endmodule

@@ rtl/core/dsm_checker.sv @@
module dsm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dsm_pkg::in_word_t  s_word,
    input logic               m_valid,
    input logic               m_ready,
    input dsm_pkg::out_word_t m_word
);
    import dsm_pkg::*;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is shown");

    a_load_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_word.mode |=> s_ready && !m_valid)
        else $error("multiplicand load left the idle state");

    a_busy_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_word.last_res |=> !s_ready)
        else $error("input ready before the last product digit");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_word.last_res |=> s_ready && !m_valid)
        else $error("block not idle after the last product digit");

endmodule

bind decimal_schoolbook_multiplier dsm_checker u_dsm_checker (.*);
